// ----- hdl/stc_pkg.sv -----
package stc_pkg;

    localparam int KW_SLOTS = 32;
    localparam int KW_COUNT = 20;
    localparam int POS_W = 4;
    localparam int CHAR_W = 8;
    localparam int CLASS_W = 6;
    localparam int KW_IDX_W = $clog2(KW_SLOTS);
    localparam int OP3_COUNT = 3;

    localparam logic [POS_W-1:0] POS_SAT = POS_W'(9);

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [CLASS_W-1:0] class_t;
    typedef logic [POS_W-1:0] pos_t;

    localparam class_t CLS_WORD = 6'd0;
    localparam class_t CLS_ASSIGN = 6'd1;
    localparam class_t CLS_INTEGER = 6'd2;
    localparam class_t CLS_COMMENT = 6'd3;
    localparam class_t CLS_LPAREN = 6'd4;
    localparam class_t CLS_RPAREN = 6'd5;
    localparam class_t CLS_PIPE = 6'd6;
    localparam class_t CLS_LESS = 6'd7;
    localparam class_t CLS_GREAT = 6'd8;
    localparam class_t CLS_AMP = 6'd9;
    localparam class_t CLS_NEWLINE = 6'd10;
    localparam class_t CLS_SEMI = 6'd11;
    localparam class_t CLS_AND_IF = 6'd12;
    localparam class_t CLS_OR_IF = 6'd13;
    localparam class_t CLS_DSEMI = 6'd14;
    localparam class_t CLS_DLESS = 6'd15;
    localparam class_t CLS_DGREAT = 6'd16;
    localparam class_t CLS_LESS_AND = 6'd17;
    localparam class_t CLS_GREAT_AND = 6'd18;
    localparam class_t CLS_LESS_GREAT = 6'd19;
    localparam class_t CLS_CLOBBER = 6'd20;
    localparam class_t CLS_SEMI_AND = 6'd21;
    localparam class_t CLS_DSEMI_AND = 6'd22;
    localparam class_t CLS_SEMI_PIPE = 6'd23;
    localparam class_t CLS_PIPE_AND = 6'd24;
    localparam class_t CLS_TLESS = 6'd25;
    localparam class_t CLS_AND_GREAT = 6'd26;
    localparam class_t CLS_AND_DGREAT = 6'd27;
    localparam class_t CLS_KW_BASE = 6'd28;
    localparam class_t CLS_MAX = 6'd47;

    localparam char_t CH_HASH = 8'h23;
    localparam char_t CH_EQUAL = 8'h3D;
    localparam char_t CH_UNDER = 8'h5F;
    localparam char_t CH_PLUS = 8'h2B;
    localparam char_t CH_AMP = 8'h26;
    localparam char_t CH_PIPE = 8'h7C;
    localparam char_t CH_SEMI = 8'h3B;
    localparam char_t CH_LESS = 8'h3C;
    localparam char_t CH_GREAT = 8'h3E;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_NEWLINE = 8'h0A;

    // Keyword text is left justified and padded with blanks to eight characters.
    localparam logic [63:0] KW_TEXT [KW_SLOTS] = '{
        "if      ", "then    ", "else    ", "elif    ", "fi      ",
        "do      ", "done    ", "case    ", "esac    ", "while   ",
        "until   ", "for     ", "{       ", "}       ", "!       ",
        "in      ", "select  ", "function", "time    ", "coproc  ",
        "        ", "        ", "        ", "        ", "        ",
        "        ", "        ", "        ", "        ", "        ",
        "        ", "        "
    };

    localparam pos_t KW_LEN [KW_SLOTS] = '{
        4'd2, 4'd4, 4'd4, 4'd4, 4'd2, 4'd2, 4'd4, 4'd4, 4'd4, 4'd5,
        4'd5, 4'd3, 4'd1, 4'd1, 4'd1, 4'd2, 4'd6, 4'd8, 4'd4, 4'd6,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0
    };

    localparam logic [23:0] OP3_TEXT [OP3_COUNT] = '{"<<<", ";;&", "&>>"};
    localparam class_t OP3_CLASS [OP3_COUNT] = '{CLS_TLESS, CLS_DSEMI_AND, CLS_AND_DGREAT};

    function automatic logic is_digit(input char_t c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input char_t c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic char_t kw_char(input logic [63:0] text, input logic [2:0] p);
        logic [2:0] slot;
        slot = 3'd7 - p;
        return text[{slot, 3'b000} +: CHAR_W];
    endfunction

    function automatic char_t op3_char(input logic [23:0] text, input logic [1:0] p);
        logic [1:0] slot;
        slot = 2'd2 - p;
        return text[{slot, 3'b000} +: CHAR_W];
    endfunction

    function automatic class_t op1_class(input char_t c);
        class_t cls;
        unique case (c)
            CH_LPAREN: cls = CLS_LPAREN;
            CH_RPAREN: cls = CLS_RPAREN;
            CH_PIPE: cls = CLS_PIPE;
            CH_LESS: cls = CLS_LESS;
            CH_GREAT: cls = CLS_GREAT;
            CH_AMP: cls = CLS_AMP;
            CH_NEWLINE: cls = CLS_NEWLINE;
            CH_SEMI: cls = CLS_SEMI;
            default: cls = CLS_WORD;
        endcase
        return cls;
    endfunction

    function automatic class_t op2_class(input char_t f, input char_t s);
        class_t cls;
        unique case (f)
            CH_AMP: cls = (s == CH_GREAT) ? CLS_AND_GREAT : CLS_AND_IF;
            CH_PIPE: cls = (s == CH_AMP) ? CLS_PIPE_AND : CLS_OR_IF;
            CH_SEMI: cls = (s == CH_AMP) ? CLS_SEMI_AND
                         : ((s == CH_PIPE) ? CLS_SEMI_PIPE : CLS_DSEMI);
            CH_GREAT: cls = (s == CH_GREAT) ? CLS_DGREAT
                          : ((s == CH_AMP) ? CLS_GREAT_AND : CLS_CLOBBER);
            CH_LESS: cls = (s == CH_LESS) ? CLS_DLESS
                         : ((s == CH_AMP) ? CLS_LESS_AND : CLS_LESS_GREAT);
            default: cls = CLS_WORD;
        endcase
        return cls;
    endfunction

endpackage

// ----- hdl/shell_token_classifier_core.sv -----
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  char_in[7:0], last_char
// out       output     out_valid/out_stall token_class[5:0]
//
// Each character is registered on acceptance and updates the token state at the
// next edge unless a stalled output holds it; one character can be taken in
// every cycle while in_stall is low. The class code is written to the output
// register when the last character leaves the input register.
// Reset clears the token state and both valid flags.
// A stalled output holds the input register only when it carries a last
// character; other characters keep flowing into the token state.
module shell_token_classifier_core #(
    parameter int NUM_KEYWORDS = stc_pkg::KW_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [stc_pkg::CHAR_W-1:0]    char_in,
    input  logic                          last_char,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [stc_pkg::CLASS_W-1:0]   token_class
);

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    stc_pkg::char_t             s1_char_reg;
    logic                       s1_last_reg;
    logic                       s1_fire;
    logic                       out_free;
    logic                       in_take;

    stc_pkg::pos_t              pos_reg;
    stc_pkg::pos_t              pos_next;
    stc_pkg::char_t             first_reg;
    stc_pkg::char_t             first_next;
    stc_pkg::char_t             second_reg;
    stc_pkg::char_t             second_next;
    logic                       digits_reg;
    logic                       digits_next;
    logic [NUM_KEYWORDS-1:0]    kw_alive_reg;
    logic [NUM_KEYWORDS-1:0]    kw_alive_next;
    logic                       equal_reg;
    logic                       equal_next;
    logic                       invalid_reg;
    logic                       invalid_next;
    logic                       plus_reg;
    logic                       plus_next;
    logic [stc_pkg::OP3_COUNT-1:0] op3_alive_reg;
    logic [stc_pkg::OP3_COUNT-1:0] op3_alive_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    stc_pkg::class_t            class_reg;
    stc_pkg::class_t            class_next;

    logic [stc_pkg::KW_IDX_W-1:0] kw_idx;
    logic                       kw_found;
    stc_pkg::pos_t              tok_len;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_take = in_valid && !in_stall;
    assign s1_valid_next = in_take ? 1'b1 : (s1_valid_reg && !s1_fire);
    assign tok_len = pos_reg + stc_pkg::POS_W'(1);

    always_comb
    begin
        char_t_block : begin
            stc_pkg::char_t c;
            c = s1_char_reg;
            first_next = (pos_reg == '0) ? c : first_reg;
            second_next = (pos_reg == stc_pkg::POS_W'(1)) ? c : second_reg;
            digits_next = digits_reg && stc_pkg::is_digit(c);
            pos_next = (pos_reg < stc_pkg::POS_SAT) ? tok_len : pos_reg;
            for (int i = 0; i < NUM_KEYWORDS; i++)
            begin
                kw_alive_next[i] = kw_alive_reg[i] && (pos_reg < stc_pkg::KW_LEN[i])
                    && (stc_pkg::kw_char(stc_pkg::KW_TEXT[i], pos_reg[2:0]) == c);
            end
            for (int i = 0; i < stc_pkg::OP3_COUNT; i++)
            begin
                op3_alive_next[i] = op3_alive_reg[i] && (pos_reg < stc_pkg::POS_W'(3))
                    && (stc_pkg::op3_char(stc_pkg::OP3_TEXT[i], pos_reg[1:0]) == c);
            end
            equal_next = equal_reg;
            invalid_next = invalid_reg;
            plus_next = plus_reg;
            if ((pos_reg != '0) && !equal_reg)
            begin
                if (plus_reg && (c != stc_pkg::CH_EQUAL))
                begin
                    invalid_next = 1'b1;
                end
                plus_next = 1'b0;
                if (c == stc_pkg::CH_EQUAL)
                begin
                    equal_next = 1'b1;
                end
                else if (c == stc_pkg::CH_PLUS)
                begin
                    plus_next = 1'b1;
                end
                else if (!stc_pkg::is_alpha(c) && !stc_pkg::is_digit(c)
                         && (c != stc_pkg::CH_UNDER))
                begin
                    invalid_next = 1'b1;
                end
            end
        end
    end

    // At most one keyword can match its full length, so the index is an OR.
    always_comb
    begin
        kw_idx = '0;
        kw_found = 1'b0;
        for (int i = 0; i < NUM_KEYWORDS; i++)
        begin
            if (kw_alive_next[i] && (stc_pkg::KW_LEN[i] == tok_len))
            begin
                kw_found = 1'b1;
                kw_idx = kw_idx | stc_pkg::KW_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        class_next = stc_pkg::CLS_WORD;
        if (pos_reg == '0)
        begin
            class_next = stc_pkg::op1_class(s1_char_reg);
            if (class_next == stc_pkg::CLS_WORD)
            begin
                if (kw_found)
                begin
                    class_next = stc_pkg::CLS_KW_BASE + stc_pkg::CLASS_W'(kw_idx);
                end
                else if (stc_pkg::is_digit(s1_char_reg))
                begin
                    class_next = stc_pkg::CLS_INTEGER;
                end
            end
        end
        else if (pos_reg == stc_pkg::POS_W'(1))
        begin
            class_next = stc_pkg::op2_class(first_next, second_next);
            if (class_next == stc_pkg::CLS_WORD)
            begin
                if (stc_pkg::is_digit(first_next) && stc_pkg::is_digit(second_next))
                begin
                    class_next = stc_pkg::CLS_INTEGER;
                end
                else if (kw_found)
                begin
                    class_next = stc_pkg::CLS_KW_BASE + stc_pkg::CLASS_W'(kw_idx);
                end
                else if (stc_pkg::is_alpha(first_next) && (second_next == stc_pkg::CH_EQUAL))
                begin
                    class_next = stc_pkg::CLS_ASSIGN;
                end
            end
        end
        else if (first_next == stc_pkg::CH_HASH)
        begin
            class_next = stc_pkg::CLS_COMMENT;
        end
        else if (stc_pkg::is_digit(first_next))
        begin
            class_next = digits_next ? stc_pkg::CLS_INTEGER : stc_pkg::CLS_WORD;
        end
        else if (stc_pkg::is_alpha(first_next))
        begin
            if (kw_found)
            begin
                class_next = stc_pkg::CLS_KW_BASE + stc_pkg::CLASS_W'(kw_idx);
            end
            else if (equal_next && !invalid_next)
            begin
                class_next = stc_pkg::CLS_ASSIGN;
            end
        end
        else if (pos_reg == stc_pkg::POS_W'(2))
        begin
            if (op3_alive_next[0])
            begin
                class_next = stc_pkg::OP3_CLASS[0];
            end
            else if (op3_alive_next[1])
            begin
                class_next = stc_pkg::OP3_CLASS[1];
            end
            else if (op3_alive_next[2])
            begin
                class_next = stc_pkg::OP3_CLASS[2];
            end
        end
    end

    assign out_valid_next = (s1_fire && s1_last_reg) ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg <= '0;
            first_reg <= '0;
            second_reg <= '0;
            digits_reg <= 1'b1;
            kw_alive_reg <= '1;
            equal_reg <= 1'b0;
            invalid_reg <= 1'b0;
            plus_reg <= 1'b0;
            op3_alive_reg <= '1;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                if (s1_last_reg)
                begin
                    pos_reg <= '0;
                    first_reg <= '0;
                    second_reg <= '0;
                    digits_reg <= 1'b1;
                    kw_alive_reg <= '1;
                    equal_reg <= 1'b0;
                    invalid_reg <= 1'b0;
                    plus_reg <= 1'b0;
                    op3_alive_reg <= '1;
                end
                else
                begin
                    pos_reg <= pos_next;
                    first_reg <= first_next;
                    second_reg <= second_next;
                    digits_reg <= digits_next;
                    kw_alive_reg <= kw_alive_next;
                    equal_reg <= equal_next;
                    invalid_reg <= invalid_next;
                    plus_reg <= plus_next;
                    op3_alive_reg <= op3_alive_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg <= char_in;
            s1_last_reg <= last_char;
        end
        if (s1_fire && s1_last_reg)
        begin
            class_reg <= class_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign token_class = class_reg;

    a_class_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (token_class <= stc_pkg::CLS_MAX))
        else $error("token class out of range");

    a_pos_cleared : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (pos_reg == '0))
        else $error("position not cleared after a last character");

    a_pos_sat : assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= stc_pkg::POS_SAT)
        else $error("position beyond saturation");

    a_op3_dead : assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg > stc_pkg::POS_W'(3)) |-> (op3_alive_reg == '0))
        else $error("three-character operator alive in a long token");

    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_last_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

endmodule

// ----- tb/tb_shell_token_classifier_core.sv -----
`timescale 1ns / 100ps

function automatic string keyword_word(input int idx);
    case (idx)
        0: return "if";
        1: return "then";
        2: return "else";
        3: return "elif";
        4: return "fi";
        5: return "do";
        6: return "done";
        7: return "case";
        8: return "esac";
        9: return "while";
        10: return "until";
        11: return "for";
        12: return "{";
        13: return "}";
        14: return "!";
        15: return "in";
        16: return "select";
        17: return "function";
        18: return "time";
        default: return "coproc";
    endcase
endfunction

class token_scoreboard;
    stc_pkg::class_t class_fifo[$];
    int unsigned failures;
    bit [3:0] char_count;
    stc_pkg::char_t first_c;
    stc_pkg::char_t second_c;
    bit all_dig;
    bit [19:0] kw_alive;
    bit eq_seen;
    bit name_bad;
    bit plus_pend;
    bit [2:0] op3_alive;

    function new();
        failures = 0;
        clear_token();
    endfunction

    function void clear_token();
        char_count = 0;
        first_c = 0;
        second_c = 0;
        all_dig = 1;
        kw_alive = '1;
        eq_seen = 0;
        name_bad = 0;
        plus_pend = 0;
        op3_alive = '1;
    endfunction

    function bit is_num(input stc_pkg::char_t c);
        return c >= "0" && c <= "9";
    endfunction

    function bit is_letter(input stc_pkg::char_t c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function string op3_word(input int idx);
        case (idx)
            0: return "<<<";
            1: return ";;&";
            default: return "&>>";
        endcase
    endfunction

    function stc_pkg::class_t single_op(input stc_pkg::char_t c);
        case (c)
            "(": return stc_pkg::CLS_LPAREN;
            ")": return stc_pkg::CLS_RPAREN;
            "|": return stc_pkg::CLS_PIPE;
            "<": return stc_pkg::CLS_LESS;
            ">": return stc_pkg::CLS_GREAT;
            "&": return stc_pkg::CLS_AMP;
            "\n": return stc_pkg::CLS_NEWLINE;
            ";": return stc_pkg::CLS_SEMI;
            default: return stc_pkg::CLS_WORD;
        endcase
    endfunction

    function stc_pkg::class_t pair_op(input stc_pkg::char_t f, input stc_pkg::char_t s);
        case (f)
            "&": return (s == ">") ? stc_pkg::CLS_AND_GREAT : stc_pkg::CLS_AND_IF;
            "|": return (s == "&") ? stc_pkg::CLS_PIPE_AND : stc_pkg::CLS_OR_IF;
            ";": return (s == "&") ? stc_pkg::CLS_SEMI_AND
                     : ((s == "|") ? stc_pkg::CLS_SEMI_PIPE : stc_pkg::CLS_DSEMI);
            ">": return (s == ">") ? stc_pkg::CLS_DGREAT
                     : ((s == "&") ? stc_pkg::CLS_GREAT_AND : stc_pkg::CLS_CLOBBER);
            "<": return (s == "<") ? stc_pkg::CLS_DLESS
                     : ((s == "&") ? stc_pkg::CLS_LESS_AND : stc_pkg::CLS_LESS_GREAT);
            default: return stc_pkg::CLS_WORD;
        endcase
    endfunction

    function void take_char(input stc_pkg::char_t c, input bit last);
        string w;
        int p;
        int n;
        int k;
        stc_pkg::class_t cls;
        p = char_count;
        if (p == 0) first_c = c;
        if (p == 1) second_c = c;
        if (!is_num(c)) all_dig = 0;
        for (int i = 0; i < 20; i++)
        begin
            w = keyword_word(i);
            if (p >= w.len() || stc_pkg::char_t'(w[p]) != c) kw_alive[i] = 0;
        end
        for (int i = 0; i < 3; i++)
        begin
            w = op3_word(i);
            if (p >= 3 || stc_pkg::char_t'(w[p]) != c) op3_alive[i] = 0;
        end
        if (p >= 1 && !eq_seen)
        begin
            if (plus_pend && c != "=") name_bad = 1;
            plus_pend = 0;
            if (c == "=") eq_seen = 1;
            else if (c == "+") plus_pend = 1;
            else if (!is_letter(c) && !is_num(c) && c != "_") name_bad = 1;
        end
        if (char_count < 9) char_count = char_count + 1;
        if (!last) return;

        n = p + 1;
        k = -1;
        for (int i = 0; i < 20; i++)
            if (k < 0 && kw_alive[i] && keyword_word(i).len() == n) k = i;
        cls = stc_pkg::CLS_WORD;
        if (n == 1)
        begin
            cls = single_op(c);
            if (cls == stc_pkg::CLS_WORD)
            begin
                if (k >= 0) cls = stc_pkg::class_t'(stc_pkg::CLS_KW_BASE + k);
                else if (is_num(c)) cls = stc_pkg::CLS_INTEGER;
            end
        end
        else if (n == 2)
        begin
            cls = pair_op(first_c, second_c);
            if (cls == stc_pkg::CLS_WORD)
            begin
                if (is_num(first_c) && is_num(second_c)) cls = stc_pkg::CLS_INTEGER;
                else if (k >= 0) cls = stc_pkg::class_t'(stc_pkg::CLS_KW_BASE + k);
                else if (is_letter(first_c) && second_c == "=") cls = stc_pkg::CLS_ASSIGN;
            end
        end
        else if (first_c == "#")
            cls = stc_pkg::CLS_COMMENT;
        else if (is_num(first_c))
            cls = all_dig ? stc_pkg::CLS_INTEGER : stc_pkg::CLS_WORD;
        else if (is_letter(first_c))
        begin
            if (k >= 0) cls = stc_pkg::class_t'(stc_pkg::CLS_KW_BASE + k);
            else if (eq_seen && !name_bad) cls = stc_pkg::CLS_ASSIGN;
        end
        else if (n == 3)
        begin
            if (op3_alive[0]) cls = stc_pkg::CLS_TLESS;
            else if (op3_alive[1]) cls = stc_pkg::CLS_DSEMI_AND;
            else if (op3_alive[2]) cls = stc_pkg::CLS_AND_DGREAT;
        end
        class_fifo.push_back(cls);
        clear_token();
    endfunction

    function void check_class(input stc_pkg::class_t actual);
        stc_pkg::class_t exp_cls;
        if (class_fifo.size() == 0)
        begin
            $error("token_class: unexpected transaction, actual %0d", actual);
            failures++;
            return;
        end
        exp_cls = class_fifo.pop_front();
        if (actual !== exp_cls)
        begin
            $error("token_class expected %0d actual %0d", exp_cls, actual);
            failures++;
        end
    endfunction
endclass

module tb_shell_token_classifier_core;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    stc_pkg::char_t char_in = '0;
    logic last_char = 0;
    logic out_valid;
    logic out_stall = 0;
    stc_pkg::class_t token_class;

    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    logic hold_off = 0;
    logic start_hold = 0;
    int unsigned chars_sent = 0;
    stc_pkg::char_t tok_q[$];
    token_scoreboard sb;

    shell_token_classifier_core u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .char_in(char_in),
        .last_char(last_char),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .token_class(token_class)
    );

    always #4 clk = ~clk;

    task automatic send_char(input stc_pkg::char_t c, input bit last);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        char_in <= c;
        last_char <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.take_char(c, last);
        chars_sent++;
    endtask

    task automatic send_queue();
        for (int i = 0; i < tok_q.size(); i++)
            send_char(tok_q[i], i == tok_q.size() - 1);
    endtask

    task automatic send_text(input string s);
        tok_q.delete();
        for (int i = 0; i < s.len(); i++) tok_q.push_back(stc_pkg::char_t'(s[i]));
        send_queue();
    endtask

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) tok_q.push_back(stc_pkg::char_t'(s[i]));
    endfunction

    function automatic stc_pkg::char_t name_char();
        case ($urandom_range(3))
            0: return stc_pkg::char_t'("a" + $urandom_range(25));
            1: return stc_pkg::char_t'("A" + $urandom_range(25));
            2: return stc_pkg::char_t'("0" + $urandom_range(9));
            default: return "_";
        endcase
    endfunction

    function automatic stc_pkg::char_t printable_char();
        return stc_pkg::char_t'($urandom_range(126, 32));
    endfunction

    function automatic string op_word(input int idx);
        case (idx)
            0: return "(";
            1: return ")";
            2: return "|";
            3: return "<";
            4: return ">";
            5: return "&";
            6: return "\n";
            7: return ";";
            8: return "&&";
            9: return "||";
            10: return ";;";
            11: return "<<";
            12: return ">>";
            13: return "<&";
            14: return ">&";
            15: return "<>";
            16: return ">|";
            17: return ";&";
            18: return ";;&";
            19: return ";|";
            20: return "|&";
            21: return "<<<";
            22: return "&>";
            23: return "&>>";
            default: return "<<-";
        endcase
    endfunction

    function automatic void make_token();
        int kind;
        int n;
        int j;
        tok_q.delete();
        kind = $urandom_range(99);
        if (kind < 15)
            push_text(keyword_word($urandom_range(19)));
        else if (kind < 25)
        begin
            push_text(keyword_word($urandom_range(19)));
            j = $urandom_range(tok_q.size() - 1);
            case ($urandom_range(3))
                0: tok_q[j] = printable_char();
                1: tok_q.push_back(name_char());
                2: if (tok_q.size() > 1) void'(tok_q.pop_back());
                default: tok_q.push_front(tok_q[0]);
            endcase
        end
        else if (kind < 45)
        begin
            if ($urandom_range(3) == 0)
            begin
                case ($urandom_range(4))
                    0: tok_q.push_back("&");
                    1: tok_q.push_back("|");
                    2: tok_q.push_back(";");
                    3: tok_q.push_back(">");
                    default: tok_q.push_back("<");
                endcase
                tok_q.push_back(stc_pkg::char_t'($urandom_range(255)));
                if ($urandom_range(2) == 0)
                    tok_q.push_back(stc_pkg::char_t'($urandom_range(255)));
            end
            else
                push_text(op_word($urandom_range(24)));
        end
        else if (kind < 62)
        begin
            if ($urandom_range(9) == 0) tok_q.push_back(name_char());
            else tok_q.push_back(stc_pkg::char_t'("a" + $urandom_range(25)));
            n = $urandom_range(5);
            for (int i = 0; i < n; i++) tok_q.push_back(name_char());
            if ($urandom_range(7) == 0)
                tok_q.insert($urandom_range(tok_q.size()),
                             stc_pkg::char_t'($urandom_range(255)));
            if ($urandom_range(9) == 0)
                tok_q.insert($urandom_range(tok_q.size()), "+");
            if ($urandom_range(2) == 0) tok_q.push_back("+");
            tok_q.push_back("=");
            n = $urandom_range(5);
            for (int i = 0; i < n; i++) tok_q.push_back(printable_char());
        end
        else if (kind < 72)
        begin
            n = $urandom_range(12, 1);
            for (int i = 0; i < n; i++)
                tok_q.push_back(stc_pkg::char_t'("0" + $urandom_range(9)));
            if ($urandom_range(4) == 0)
                tok_q[$urandom_range(n - 1)] = stc_pkg::char_t'($urandom_range(255));
        end
        else if (kind < 80)
        begin
            tok_q.push_back("#");
            n = $urandom_range(8);
            for (int i = 0; i < n; i++) tok_q.push_back(stc_pkg::char_t'($urandom_range(255)));
        end
        else if (kind < 88)
        begin
            if ($urandom_range(1) == 0) push_text(keyword_word($urandom_range(19)));
            else tok_q.push_back(stc_pkg::char_t'("A" + $urandom_range(25)));
            n = $urandom_range(13);
            for (int i = 0; i < n; i++) tok_q.push_back(name_char());
        end
        else
        begin
            n = $urandom_range(12, 1);
            for (int i = 0; i < n; i++) tok_q.push_back(stc_pkg::char_t'($urandom_range(255)));
        end
    endfunction

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall) sb.check_class(token_class);
            out_stall <= hold_off || ($urandom_range(99) < recv_idle);
        end
    end

    initial
    begin
        @(posedge start_hold);
        hold_off <= 1;
        repeat (300) @(posedge clk);
        hold_off <= 0;
    end

    initial
    begin
        #5000000;
        $display("** shell_token_classifier_core: FAILED **");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_text("(");
        send_text("\n");
        send_text("&&");
        send_text(";|");
        send_text("&q");
        send_text("<<<");
        send_text(";;&");
        send_text("&>>");
        send_text("<<-");
        send_text("if");
        send_text("{");
        send_text("function");
        send_text("functionxyz");
        send_text("a=");
        send_text("ab+=c");
        send_text("a+b=1");
        send_text("x_1=9");
        send_text("42");
        send_text("12a");
        send_text("#c!");
        send_char(8'h00, 1);
        send_char(8'hFF, 0);
        send_char(8'h80, 1);
        send_text("5");

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
                1:
                begin
                    send_idle = 84;
                    recv_idle = 0;
                end
                2:
                begin
                    send_idle = 0;
                    recv_idle = 84;
                end
                default:
                begin
                    send_idle = 35;
                    recv_idle = 35;
                end
            endcase
            while (chars_sent < 60 + (phase + 1) * 350)
            begin
                if (phase == 0 && chars_sent > 150 && !start_hold) start_hold <= 1;
                make_token();
                send_queue();
            end
        end
        in_valid <= 0;

        while (sb.class_fifo.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.class_fifo.size() == 0)
            $display("** shell_token_classifier_core: PASSED **");
        else
            $display("** shell_token_classifier_core: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/stc_pkg.sv
hdl/shell_token_classifier_core.sv
tb/tb_shell_token_classifier_core.sv
